// ===== rtl/gdfw_pkg.sv =====
// shared types and constants for the depth-first graph walk block
// no dependencies
package gdfw_pkg;

  localparam int DEF_NODES   = 64;
  localparam int DEF_ENTRIES = 512;
  localparam int NODE_PORT_W = 6;

  localparam logic OP_EDGE      = 1'b0;
  localparam logic OP_WALK      = 1'b1;
  localparam logic STATUS_VISIT = 1'b0;
  localparam logic STATUS_FULL  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_E_A0,
    ST_E_A1,
    ST_E_B0,
    ST_E_B1,
    ST_W_START,
    ST_W_PUSH,
    ST_W_STEP,
    ST_W_ENT,
    ST_W_POP,
    ST_W_DONE
  } state_t;

  // write enables toward the graph store
  typedef struct packed {
    logic head_we;
    logic tail_we;
    logic tgt_we;
    logic next_we;
  } store_we_t;

endpackage

// ===== rtl/gdfw_store.sv =====
// adjacency list storage: per-node head/tail memories and the entry memory
// depends on gdfw_pkg
module gdfw_store #(
  parameter int NODES   = 64,
  parameter int ENTRIES = 512,
  parameter int NW      = $clog2(NODES),
  parameter int EW      = $clog2(ENTRIES)
) (
  input  logic                clk,
  input  gdfw_pkg::store_we_t we,
  input  logic [NW-1:0]       list_addr,
  input  logic [EW-1:0]       list_wdata,
  input  logic [EW-1:0]       ent_waddr,
  input  logic [NW-1:0]       ent_tgt_wdata,
  input  logic [EW-1:0]       ent_next_wdata,
  input  logic [EW-1:0]       ent_raddr,
  output logic [EW-1:0]       head_rd,
  output logic [EW-1:0]       tail_rd,
  output logic [NW-1:0]       tgt_rd,
  output logic [EW-1:0]       next_rd
);
  import gdfw_pkg::*;

  logic [EW-1:0] head_mem [NODES];
  logic [EW-1:0] tail_mem [NODES];
  logic [NW-1:0] tgt_mem  [ENTRIES];
  logic [EW-1:0] next_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we.head_we) begin
      head_mem[list_addr] <= list_wdata;
    end
    if (we.tail_we) begin
      tail_mem[list_addr] <= list_wdata;
    end
    head_rd <= head_mem[list_addr];
    tail_rd <= tail_mem[list_addr];
  end

  always_ff @(posedge clk) begin
    if (we.tgt_we) begin
      tgt_mem[ent_waddr] <= ent_tgt_wdata;
    end
    if (we.next_we) begin
      next_mem[ent_waddr] <= ent_next_wdata;
    end
    tgt_rd  <= tgt_mem[ent_raddr];
    next_rd <= next_mem[ent_raddr];
  end

endmodule

// ===== rtl/gdfw_stack.sv =====
// walk stack memory holding the saved levels below the top of stack
// depends on gdfw_pkg
module gdfw_stack #(
  parameter int NODES = 64,
  parameter int NW    = $clog2(NODES),
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [NW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [NW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  import gdfw_pkg::*;

  logic [DW-1:0] mem [NODES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/graph_depth_first_walk_core.sv =====
// depth-first walk over an adjacency-list graph: top level with the sequencer
// edge add: two list appends (ST_E_A0/A1 for end a, ST_E_B0/B1 for end b), read then write each
// walk: ST_W_START sets up, then ST_W_STEP and ST_W_ENT per list entry scanned, ST_W_PUSH per new
//   node and ST_W_POP per stack pop; the entry and head/tail memory ports set the pace
// results are one-cycle strobes on out_valid, the receiver cannot stall
// reset (sync, rst_n low) empties all lists, clears marks, start_node = 1
module graph_depth_first_walk_core #(
  parameter int NODES   = gdfw_pkg::DEF_NODES,
  parameter int ENTRIES = gdfw_pkg::DEF_ENTRIES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_operation,
  input  logic [gdfw_pkg::NODE_PORT_W-1:0] in_end_a,
  input  logic [gdfw_pkg::NODE_PORT_W-1:0] in_end_b,
  output logic                             out_valid,
  output logic [gdfw_pkg::NODE_PORT_W-1:0] out_visited_node,
  output logic                             out_status,
  output logic                             out_last,
  input  logic                             cfg_wr_en,
  input  logic [gdfw_pkg::NODE_PORT_W-1:0] cfg_wr_data
);
  import gdfw_pkg::*;

  localparam int NW = $clog2(NODES);
  localparam int EW = $clog2(ENTRIES);
  localparam int UW = $clog2(ENTRIES + 1);
  localparam int SW = $clog2(NODES + 1);
  localparam int DW = 2 * EW + 1;

  state_t state_r, state_nxt;

  logic [NODE_PORT_W-1:0] start_r;
  logic [NW-1:0]          ea_r, ea_nxt, eb_r, eb_nxt;
  logic [UW-1:0]          used_r, used_nxt;
  logic [NODES-1:0]       nonempty_r, nonempty_nxt;
  logic [NODES-1:0]       seen_r, seen_nxt;
  logic [EW-1:0]          cur_r, cur_nxt, tail_r, tail_nxt;
  logic                   more_r, more_nxt;
  logic [SW-1:0]          sp_r, sp_nxt;
  logic [NW-1:0]          v_r, v_nxt, pend_r, pend_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [NW-1:0]          out_node_r, out_node_nxt;
  logic                   out_status_r, out_status_nxt;
  logic                   out_last_r, out_last_nxt;

  store_we_t     st_we;
  logic [NW-1:0] list_addr, tgt_rd;
  logic [EW-1:0] list_wdata, ent_waddr, ent_next_wdata, ent_raddr;
  logic [EW-1:0] head_rd, tail_rd, next_rd;

  logic          stk_we;
  logic [NW-1:0] stk_waddr, stk_raddr;
  logic [DW-1:0] stk_wdata, stk_rdata;

  logic          accept;
  logic          edge_bad, full, start_bad, push_ok, step_more;
  logic [EW-1:0] step_cur;
  logic [NW-1:0] owner, other;

  gdfw_store #(.NODES(NODES), .ENTRIES(ENTRIES), .NW(NW), .EW(EW)) u_store (
    .clk           (clk),
    .we            (st_we),
    .list_addr     (list_addr),
    .list_wdata    (list_wdata),
    .ent_waddr     (ent_waddr),
    .ent_tgt_wdata (other),
    .ent_next_wdata(ent_next_wdata),
    .ent_raddr     (ent_raddr),
    .head_rd       (head_rd),
    .tail_rd       (tail_rd),
    .tgt_rd        (tgt_rd),
    .next_rd       (next_rd)
  );

  gdfw_stack #(.NODES(NODES), .NW(NW), .DW(DW)) u_stack (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(stk_wdata),
    .raddr(stk_raddr),
    .rdata(stk_rdata)
  );

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign edge_bad  = ({1'b0, in_end_a} >= (NODE_PORT_W+1)'(NODES)) ||
                     ({1'b0, in_end_b} >= (NODE_PORT_W+1)'(NODES));
  assign full      = ({1'b0, used_r} + (UW+1)'(2)) > (UW+1)'(ENTRIES);
  assign start_bad = ({1'b0, start_r} >= (NODE_PORT_W+1)'(NODES));

  // owner of the list being appended and the neighbor stored in it
  assign owner = (state_r == ST_E_B0 || state_r == ST_E_B1) ? eb_r : ea_r;
  assign other = (state_r == ST_E_B0 || state_r == ST_E_B1) ? ea_r : eb_r;

  // scan step on the top-of-stack level
  assign step_more = (cur_r != tail_r);
  assign step_cur  = step_more ? next_rd : cur_r;
  assign push_ok   = !seen_r[tgt_rd] && (sp_r < SW'(NODES));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_operation == OP_WALK) begin
            if (!start_bad) begin
              state_nxt = ST_W_START;
            end
          end else if (!edge_bad && !full) begin
            state_nxt = ST_E_A0;
          end
        end
      end
      ST_E_A0:    state_nxt = ST_E_A1;
      ST_E_A1:    state_nxt = ST_E_B0;
      ST_E_B0:    state_nxt = ST_E_B1;
      ST_E_B1:    state_nxt = ST_IDLE;
      ST_W_START: state_nxt = ST_W_PUSH;
      ST_W_PUSH:  state_nxt = ST_W_STEP;
      ST_W_STEP: begin
        if (more_r) begin
          state_nxt = ST_W_ENT;
        end else if (sp_r == SW'(1)) begin
          state_nxt = ST_W_DONE;
        end else begin
          state_nxt = ST_W_POP;
        end
      end
      ST_W_ENT:   state_nxt = push_ok ? ST_W_PUSH : ST_W_STEP;
      ST_W_POP:   state_nxt = ST_W_STEP;
      ST_W_DONE:  state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    ea_nxt         = ea_r;
    eb_nxt         = eb_r;
    used_nxt       = used_r;
    nonempty_nxt   = nonempty_r;
    seen_nxt       = seen_r;
    cur_nxt        = cur_r;
    tail_nxt       = tail_r;
    more_nxt       = more_r;
    sp_nxt         = sp_r;
    v_nxt          = v_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = 1'b0;
    out_node_nxt   = out_node_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    st_we          = '0;
    list_addr      = owner;
    list_wdata     = used_r[EW-1:0];
    ent_waddr      = used_r[EW-1:0];
    ent_next_wdata = used_r[EW-1:0];
    ent_raddr      = cur_r;
    stk_we         = 1'b0;
    stk_waddr      = NW'(sp_r - SW'(1));
    stk_wdata      = {cur_r, tail_r, more_r};
    stk_raddr      = NW'(sp_r - SW'(2));
    case (state_r)
      ST_IDLE: begin
        ea_nxt = in_end_a[NW-1:0];
        eb_nxt = in_end_b[NW-1:0];
        if (accept && in_operation == OP_EDGE && !edge_bad && full) begin
          out_valid_nxt  = 1'b1;
          out_node_nxt   = '0;
          out_status_nxt = STATUS_FULL;
          out_last_nxt   = 1'b1;
        end
      end
      ST_E_A0, ST_E_B0: begin
        // new entry gets its target; tail of the owner comes back next cycle
        st_we.tgt_we = 1'b1;
      end
      ST_E_A1, ST_E_B1: begin
        if (nonempty_r[owner]) begin
          st_we.next_we = 1'b1;
          ent_waddr     = tail_rd;
        end else begin
          st_we.head_we = 1'b1;
        end
        st_we.tail_we        = 1'b1;
        nonempty_nxt[owner]  = 1'b1;
        used_nxt             = used_r + UW'(1);
      end
      ST_W_START: begin
        list_addr        = start_r[NW-1:0];
        seen_nxt         = '0;
        seen_nxt[start_r[NW-1:0]] = 1'b1;
        pend_nxt         = start_r[NW-1:0];
        v_nxt            = start_r[NW-1:0];
        sp_nxt           = '0;
      end
      ST_W_PUSH: begin
        list_addr = v_r;
        cur_nxt   = head_rd;
        tail_nxt  = tail_rd;
        more_nxt  = nonempty_r[v_r];
        sp_nxt    = sp_r + SW'(1);
      end
      ST_W_STEP: begin
        if (!more_r && sp_r != SW'(1)) begin
          sp_nxt = sp_r - SW'(1);
        end
      end
      ST_W_ENT: begin
        list_addr = tgt_rd;
        more_nxt  = step_more;
        cur_nxt   = step_cur;
        if (push_ok) begin
          seen_nxt[tgt_rd] = 1'b1;
          out_valid_nxt    = 1'b1;
          out_node_nxt     = pend_r;
          out_status_nxt   = STATUS_VISIT;
          out_last_nxt     = 1'b0;
          pend_nxt         = tgt_rd;
          v_nxt            = tgt_rd;
          stk_we           = 1'b1;
          stk_wdata        = {step_cur, tail_r, step_more};
        end
      end
      ST_W_POP: begin
        {cur_nxt, tail_nxt, more_nxt} = stk_rdata;
      end
      ST_W_DONE: begin
        out_valid_nxt  = 1'b1;
        out_node_nxt   = pend_r;
        out_status_nxt = STATUS_VISIT;
        out_last_nxt   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= NODE_PORT_W'(1);
      used_r      <= '0;
      nonempty_r  <= '0;
      seen_r      <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        start_r <= cfg_wr_data;
      end
      used_r      <= used_nxt;
      nonempty_r  <= nonempty_nxt;
      seen_r      <= seen_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ea_r         <= ea_nxt;
    eb_r         <= eb_nxt;
    cur_r        <= cur_nxt;
    tail_r       <= tail_nxt;
    more_r       <= more_nxt;
    v_r          <= v_nxt;
    pend_r       <= pend_nxt;
    out_node_r   <= out_node_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_visited_node = NODE_PORT_W'(out_node_r);
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

  a_done_emits_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_W_DONE |=> out_valid && out_last)
    else $error("walk end without final result");

  a_full_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_FULL |-> out_last)
    else $error("store full result not marked last");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SW'(NODES))
    else $error("walk stack overflow");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, used_r} <= (UW+1)'(ENTRIES))
    else $error("entry count past store size");

endmodule
